// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/feci_pkg.sv =====
package feci_pkg;

    // Field widths of the input and result words.
    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int COUNT_W = 5;

    // Size of the managed address space, in address bits.
    localparam int ADDRESS_BITS = 16;

    // Saturation limits of the result fields.
    localparam int unsigned LEN_CAP   = 131071;
    localparam int unsigned COUNT_CAP = 31;

    // Status codes of the result word.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One free extent as it is held in the table memory.
    typedef struct packed {
        logic [LEN_W-1:0]   size;
        logic [START_W-1:0] base;
    } feci_entry_t;

endpackage

// ===== rtl/feci_ram.sv =====
module feci_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  feci_pkg::feci_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output feci_pkg::feci_entry_t rd_data
);
    import feci_pkg::*;

    feci_entry_t mem [DEPTH];
    feci_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: rd_data holds the entry read at the last rd_en.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/free_extent_coalescing_insert.sv =====
// Flow: a zero-length free goes straight to loading the result word. Any other free
// searches the table for its place, decides how it merges, shifts the table where
// an insert or a double merge needs it, and loads the result word once the output is free.
// One free at a time: a new free is taken only once the result word of the last is loaded.
// The table walk handles one entry per cycle.
// Synchronous reset clears control state, output valid and extent count, not the table memory.
module free_extent_coalescing_insert #(
    parameter int MAX_EXTENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0 up: free_start[15:0], free_length[32:16], zeros[39:33].
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0 up: status[0], merged_start[16:1], merged_length[33:17],
    // extent_count[38:34], zero[39].
    output logic [39:0] m_tdata
);
    import feci_pkg::*;

    `include "assert_macros.svh"

    localparam int AW      = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW      = $clog2(MAX_EXTENTS + 1);
    localparam int SPACE_W = LEN_W + 1;
    localparam int SUM_W   = LEN_W + 2;
    localparam logic [SPACE_W-1:0] SPACE = SPACE_W'(64'd1 << ADDRESS_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHDN,
        ST_SHUP,
        ST_INS,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic prev_vld_reg, prev_vld_next;
    logic succ_vld_reg, succ_vld_next;
    feci_entry_t prev_reg, prev_next;
    feci_entry_t succ_reg, succ_next;
    logic res_status_reg, res_status_next;
    logic [START_W-1:0] res_start_reg, res_start_next;
    logic [LEN_W-1:0] res_len_reg, res_len_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    // Table memory ports.
    logic wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    feci_entry_t wr_data, rd_data;

    feci_ram #(
        .DEPTH (MAX_EXTENTS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Input unpacking and clipping of the length to the end of the address space.
    logic [START_W-1:0] in_start;
    logic [LEN_W-1:0] in_len, len_clip;
    logic [SPACE_W-1:0] room;

    assign in_start = s_tdata[15:0];
    assign in_len   = s_tdata[32:16];
    assign room     = SPACE - SPACE_W'(in_start);
    assign len_clip = ({1'b0, in_len} > room) ? room[LEN_W-1:0] : in_len;

    // Adjacency tests and the merged size.
    logic [SPACE_W-1:0] prev_end;
    logic [LEN_W-1:0] new_end;
    logic join_prev, join_next;
    logic [SUM_W-1:0] tot;
    logic [LEN_W-1:0] tot_sat;

    assign prev_end  = SPACE_W'(prev_reg.base) + SPACE_W'(prev_reg.size);
    assign new_end   = LEN_W'(start_reg) + len_reg;
    assign join_prev = prev_vld_reg && (prev_end == SPACE_W'(start_reg));
    assign join_next = succ_vld_reg && (LEN_W'(succ_reg.base) == new_end);
    assign tot       = (join_prev ? SUM_W'(prev_reg.size) : '0) + SUM_W'(len_reg)
                     + (join_next ? SUM_W'(succ_reg.size) : '0);
    assign tot_sat   = (tot > SUM_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : tot[LEN_W-1:0];

    // Neighbor indexes.
    logic [CW-1:0] idx_p1, idx_m1, pos_p1, pos_m1, cnt_m1;

    assign idx_p1 = idx_reg + CW'(1);
    assign idx_m1 = idx_reg - CW'(1);
    assign pos_p1 = pos_reg + CW'(1);
    assign pos_m1 = pos_reg - CW'(1);
    assign cnt_m1 = count_reg - CW'(1);

    // Saturated count for the result word.
    logic [COUNT_W-1:0] count_out;

    assign count_out = (32'(count_reg) > COUNT_CAP) ? COUNT_W'(COUNT_CAP) : COUNT_W'(count_reg);

    // Sequencer: search, decide, shift and emit.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        prev_vld_next   = prev_vld_reg;
        succ_vld_next   = succ_vld_reg;
        prev_next       = prev_reg;
        succ_next       = succ_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    start_next    = in_start;
                    len_next      = len_clip;
                    prev_vld_next = 1'b0;
                    succ_vld_next = 1'b0;
                    if (len_clip == '0) begin
                        // A zero-length free leaves the table alone.
                        res_status_next = STATUS_OK;
                        res_start_next  = in_start;
                        res_len_next    = '0;
                        state_next      = ST_EMIT;
                    end else if (count_reg == '0) begin
                        pos_next   = '0;
                        state_next = ST_DECIDE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Walk up the table until an extent starts at or above the free.
                if (rd_data.base < start_reg) begin
                    prev_next     = rd_data;
                    prev_vld_next = 1'b1;
                    if (idx_p1 == count_reg) begin
                        pos_next   = count_reg;
                        state_next = ST_DECIDE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_p1);
                        idx_next = idx_p1;
                    end
                end else begin
                    pos_next      = idx_reg;
                    succ_next     = rd_data;
                    succ_vld_next = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_status_next = STATUS_OK;
                if (join_prev && join_next) begin
                    // Both neighbors merge: grow the lower one, then close the gap.
                    wr_en          = 1'b1;
                    wr_addr        = AW'(pos_m1);
                    wr_data.base   = prev_reg.base;
                    wr_data.size   = tot_sat;
                    res_start_next = prev_reg.base;
                    res_len_next   = tot_sat;
                    if (pos_p1 < count_reg) begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(pos_p1);
                        idx_next   = pos_p1;
                        state_next = ST_SHDN;
                    end else begin
                        count_next = cnt_m1;
                        state_next = ST_EMIT;
                    end
                end else if (join_prev) begin
                    wr_en          = 1'b1;
                    wr_addr        = AW'(pos_m1);
                    wr_data.base   = prev_reg.base;
                    wr_data.size   = tot_sat;
                    res_start_next = prev_reg.base;
                    res_len_next   = tot_sat;
                    state_next     = ST_EMIT;
                end else if (join_next) begin
                    wr_en          = 1'b1;
                    wr_addr        = AW'(pos_reg);
                    wr_data.base   = start_reg;
                    wr_data.size   = tot_sat;
                    res_start_next = start_reg;
                    res_len_next   = tot_sat;
                    state_next     = ST_EMIT;
                end else if (32'(count_reg) >= MAX_EXTENTS) begin
                    // Table full and nothing to merge: the free is dropped.
                    res_status_next = STATUS_FULL;
                    res_start_next  = start_reg;
                    res_len_next    = '0;
                    state_next      = ST_EMIT;
                end else begin
                    res_start_next = start_reg;
                    res_len_next   = len_reg;
                    if (pos_reg == count_reg) begin
                        wr_en        = 1'b1;
                        wr_addr      = AW'(pos_reg);
                        wr_data.base = start_reg;
                        wr_data.size = len_reg;
                        count_next   = count_reg + CW'(1);
                        state_next   = ST_EMIT;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(cnt_m1);
                        idx_next   = cnt_m1;
                        state_next = ST_SHUP;
                    end
                end
            end
            ST_SHDN: begin
                // Move each entry above the removed one down by one place.
                wr_en   = 1'b1;
                wr_addr = AW'(idx_m1);
                wr_data = rd_data;
                if (idx_p1 < count_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_p1);
                    idx_next = idx_p1;
                end else begin
                    count_next = cnt_m1;
                    state_next = ST_EMIT;
                end
            end
            ST_SHUP: begin
                // Move entries up by one place, from the top down to the insert point.
                wr_en   = 1'b1;
                wr_addr = AW'(idx_p1);
                wr_data = rd_data;
                if (idx_reg == pos_reg) begin
                    state_next = ST_INS;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_m1);
                    idx_next = idx_m1;
                end
            end
            ST_INS: begin
                wr_en        = 1'b1;
                wr_addr      = AW'(pos_reg);
                wr_data.base = start_reg;
                wr_data.size = len_reg;
                count_next   = count_reg + CW'(1);
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                // Load the output register once it is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, count_out, res_len_reg, res_start_reg,
                                     res_status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        prev_vld_reg   <= prev_vld_next;
        succ_vld_reg   <= succ_vld_next;
        prev_reg       <= prev_next;
        succ_reg       <= succ_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Conditions watched by the checks below.
    logic at_rest;
    logic addr_clash;

    assign at_rest    = (state_reg == ST_IDLE) || (state_reg == ST_EMIT);
    assign addr_clash = wr_en && rd_en && (wr_addr == rd_addr);

    // The extent count never exceeds the table depth.
    `ASSERT_AT(a_count_bound, aclk, aresetn, 32'(count_reg) <= MAX_EXTENTS, "extent count overflow")

    // The table is only written while a free is being worked on.
    `ASSERT_NEVER(a_idle_write, aclk, aresetn, wr_en && at_rest, "table written while idle")

    // A shift never reads the entry it writes in the same cycle.
    `ASSERT_NEVER(a_rw_clash, aclk, aresetn, addr_clash, "read and write hit the same entry")

endmodule

// ===== test/free_extent_coalescing_insert_tb.sv =====
module free_extent_coalescing_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import feci_pkg::*;

    localparam int MAX_EXTENTS    = 16;
    localparam int SPACE          = 1 << ADDRESS_BITS;
    localparam int MAX_GAP        = 17;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;
    localparam int MISMATCH_SHOWN = 10;

    // One result word, unpacked into its fields.
    typedef struct packed {
        logic               status;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [COUNT_W-1:0] count;
    } free_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // Shadow copy of the free extent table, kept in address order.
    logic [START_W-1:0] table_base [MAX_EXTENTS];
    logic [LEN_W-1:0]   table_size [MAX_EXTENTS];
    int                 table_count = 0;

    free_result_t expected_results[$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    bit           quiet_mode     = 1'b0;
    bit           hold_request   = 1'b0;

    free_extent_coalescing_insert #(
        .MAX_EXTENTS(MAX_EXTENTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [LEN_W-1:0] cap_length(longint unsigned value);
        return (value > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(value);
    endfunction

    // Applies one free to the shadow table and returns the word the block should send.
    function automatic free_result_t coalesce_free(logic [START_W-1:0] start,
                                                   logic [LEN_W-1:0] length);
        longint unsigned len;
        longint unsigned fin;
        longint unsigned prev_end;
        longint unsigned total;
        int              room;
        int              pos;
        bit              joins_prev;
        bit              joins_next;
        free_result_t    res;
        len  = length;
        room = SPACE - int'(start);
        if (len > room) begin
            len = room;
        end
        res.status = STATUS_OK;
        res.start  = start;
        res.length = '0;
        if (len != 0) begin
            fin = start;
            fin = fin + len;
            pos = 0;
            while (pos < table_count && table_base[pos] < start) begin
                pos++;
            end
            joins_prev = 1'b0;
            if (pos > 0) begin
                prev_end   = table_base[pos-1];
                prev_end   = prev_end + table_size[pos-1];
                joins_prev = (prev_end == start);
            end
            joins_next = (pos < table_count) && (table_base[pos] == fin);

            if (joins_prev && joins_next) begin
                // The free closes the hole between two extents: all three become one.
                total = table_size[pos-1];
                total = total + len + table_size[pos];
                table_size[pos-1] = cap_length(total);
                for (int i = pos; i + 1 < table_count; i++) begin
                    table_base[i] = table_base[i+1];
                    table_size[i] = table_size[i+1];
                end
                table_count--;
                res.start  = table_base[pos-1];
                res.length = table_size[pos-1];
            end else if (joins_prev) begin
                total = table_size[pos-1];
                table_size[pos-1] = cap_length(total + len);
                res.start  = table_base[pos-1];
                res.length = table_size[pos-1];
            end else if (joins_next) begin
                total = table_size[pos];
                table_base[pos] = start;
                table_size[pos] = cap_length(total + len);
                res.start  = table_base[pos];
                res.length = table_size[pos];
            end else if (table_count >= MAX_EXTENTS) begin
                res.status = STATUS_FULL;
            end else begin
                for (int i = table_count; i > pos; i--) begin
                    table_base[i] = table_base[i-1];
                    table_size[i] = table_size[i-1];
                end
                table_base[pos] = start;
                table_size[pos] = LEN_W'(len);
                table_count++;
                res.length = LEN_W'(len);
            end
        end
        res.count = (table_count > COUNT_CAP) ? COUNT_W'(COUNT_CAP) : COUNT_W'(table_count);
        return res;
    endfunction

    function automatic int draw_gap();
        return quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Picks a free that mostly lands next to, or between, extents already held.
    function automatic void pick_random_free(output logic [START_W-1:0] start,
                                             output logic [LEN_W-1:0] length);
        int sel;
        int gran;
        int idx;
        int bound;
        sel    = $urandom_range(0, 99);
        gran   = 1 << $urandom_range(4, 11);
        start  = START_W'(($urandom_range(0, SPACE - 1) / gran) * gran);
        length = LEN_W'(gran * $urandom_range(1, 4));
        if (sel < 25 && table_count > 0) begin
            // Right after an extent.
            idx   = $urandom_range(0, table_count - 1);
            bound = table_base[idx] + table_size[idx];
            if (bound < SPACE) begin
                start = START_W'(bound);
            end
        end else if (sel < 45 && table_count > 0) begin
            // Right before an extent.
            idx   = $urandom_range(0, table_count - 1);
            bound = table_base[idx];
            if (bound >= length) begin
                start = START_W'(bound - length);
            end
        end else if (sel < 60 && table_count > 1) begin
            // Exactly fills the hole between two neighbors.
            idx   = $urandom_range(0, table_count - 2);
            bound = table_base[idx] + table_size[idx];
            if (bound < table_base[idx+1]) begin
                start  = START_W'(bound);
                length = LEN_W'(table_base[idx+1] - bound);
            end
        end else if (sel >= 90 && sel < 95) begin
            // Unstructured noise over the full field ranges.
            start  = START_W'($urandom);
            length = LEN_W'($urandom);
        end else if (sel >= 95 && sel < 98) begin
            // Long extents that reach or run past the top of the address space.
            start  = START_W'($urandom_range(0, 3) == 0 ? 0 : $urandom);
            length = LEN_W'($urandom_range(SPACE, (1 << LEN_W) - 1));
        end else if (sel >= 98) begin
            start  = START_W'($urandom);
            length = '0;
        end
    endfunction

    // Sends one free word and records the result it should produce.
    task automatic free_extent(input logic [START_W-1:0] start, input logic [LEN_W-1:0] length);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, length, start};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(coalesce_free(start, length));
    endtask

    // Stops offering words and waits until every expected result has come.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Edge values, each kind of merge, equal start addresses and a full table.
    task automatic test_directed_cases();
        free_extent(16'h1234, 17'h00000);
        free_extent(16'hFFFF, 17'h1FFFF);
        free_extent(16'h1000, 17'h00010);
        free_extent(16'h1010, 17'h00010);
        free_extent(16'h0FF0, 17'h00010);
        free_extent(16'h2000, 17'h00010);
        free_extent(16'h1020, 17'h00FE0);
        free_extent(16'h0FF0, 17'h00008);
        free_extent(16'h0FF8, 17'h00004);
        for (int k = 0; k < 12; k++) begin
            free_extent(START_W'(16'h4000 + k * 16'h0100), 17'h00010);
        end
        free_extent(16'h4010, 17'h00010);
        free_extent(16'h40F0, 17'h00010);
        free_extent(16'h4020, 17'h000D0);
        wait_for_results();
    endtask

    task automatic test_random_frees(input int n);
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        for (int k = 0; k < n; k++) begin
            pick_random_free(start, length);
            free_extent(start, length);
        end
    endtask

    // Words sent and taken with no idle cycles on either side.
    task automatic test_back_to_back(input int n);
        quiet_mode = 1'b1;
        test_random_frees(n);
        quiet_mode = 1'b0;
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering words.
    task automatic test_result_backpressure(input int n);
        hold_request = 1'b1;
        quiet_mode   = 1'b1;
        test_random_frees(n);
        quiet_mode   = 1'b0;
        wait_for_results();
    endtask

    // Receiver: a random stall before each word, or one long hold when requested.
    initial begin : result_ready
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compares each accepted result word with the oldest expected one.
    always @(posedge aclk) begin
        free_result_t got;
        free_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[0];
            got.start  = m_tdata[16:1];
            got.length = m_tdata[33:17];
            got.count  = m_tdata[38:34];
            if (expected_results.size() == 0) begin
                if (mismatch_count < MISMATCH_SHOWN) begin
                    $display("unexpected result word: status %0d start %h length %h count %0d",
                             got.status, got.start, got.length, got.count);
                end
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.start !== want.start ||
                    got.length !== want.length || got.count !== want.count) begin
                    if (mismatch_count < MISMATCH_SHOWN) begin
                        $display("mismatch: expected status %0d start %h length %h count %0d",
                                 want.status, want.start, want.length, want.count);
                        $display("          actual   status %0d start %h length %h count %0d",
                                 got.status, got.start, got.length, got.count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** free_extent_coalescing_insert: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_frees(250);
        test_back_to_back(60);
        test_result_backpressure(60);
        test_random_frees(250);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("** free_extent_coalescing_insert: PASSED **");
        end else begin
            $display("** free_extent_coalescing_insert: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/feci_pkg.sv
rtl/feci_ram.sv
rtl/free_extent_coalescing_insert.sv
test/free_extent_coalescing_insert_tb.sv
